// ----- sv/stop_and_wait_transfer_sender_defines.svh -----
// Assertion macros used by the checker file of the transfer sender.
// Depends on nothing; every macro expects clk_i and rst_ni in scope.
`ifndef STOP_AND_WAIT_TRANSFER_SENDER_DEFINES_SVH
`define STOP_AND_WAIT_TRANSFER_SENDER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SWTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/swts_pkg.sv -----
// Types, codes and constants of the stop-and-wait transfer sender.
// Used by every module of the block; depends on nothing.
package swts_pkg;

  localparam int LengthBits = 32;
  localparam logic [31:0] LenMask =
    (LengthBits >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << LengthBits) - 64'd1);

  localparam int QueueDepth = 2;
  localparam int PtrW       = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW       = $clog2(QueueDepth + 1);

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] RegSessionId   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegProtocolId  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegTotalLen    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegServerIp    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegServerPort  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegMaxRetx     = 3'd5;
  localparam logic [CfgIdxW-1:0] RegMaxChunk    = 3'd6;

  localparam logic [15:0] ShortPktLen = 16'd9;
  localparam logic [15:0] AckPktLen   = 16'd17;

  localparam logic [7:0] TypeAccept   = 8'd2;
  localparam logic [7:0] TypeReject   = 8'd3;
  localparam logic [7:0] TypeAck      = 8'd5;
  localparam logic [7:0] TypeReceived = 8'd7;

  localparam logic [1:0] ActConn = 2'd0;
  localparam logic [1:0] ActData = 2'd1;
  localparam logic [1:0] ActOk   = 2'd2;
  localparam logic [1:0] ActFail = 2'd3;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StRetry   = 3'd1;
  localparam logic [2:0] StReject  = 3'd2;
  localparam logic [2:0] StSize    = 3'd3;
  localparam logic [2:0] StType    = 3'd4;
  localparam logic [2:0] StSession = 3'd5;
  localparam logic [2:0] StNumber  = 3'd6;
  localparam logic [2:0] StSocket  = 3'd7;

  typedef enum logic [1:0] {
    CmdStart   = 2'd0,
    CmdPacket  = 2'd1,
    CmdTimeout = 2'd2,
    CmdSockErr = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [63:0] sess_key;
    logic [31:0] total_len;
    logic [31:0] server_ip;
    logic [15:0] server_port;
    logic [7:0]  max_retx;
    logic [15:0] max_chunk;
  } cfg_t;

  typedef struct packed {
    cmd_e        cmd;
    logic        src_ok;
    logic        len_short;
    logic        len_ack;
    logic        is_accept;
    logic        is_reject;
    logic        is_ack;
    logic        is_received;
    logic        sess_ok;
    logic [63:0] number;
  } evt_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] seq_number;
    logic [31:0] data_offset;
    logic [15:0] chunk_len;
    logic [2:0]  status;
  } res_t;

endpackage

// ----- sv/swts_cfg.sv -----
// Configuration register file of the transfer sender.
// Depends on swts_pkg for the register indexes and the cfg_t bundle.
module swts_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [swts_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [swts_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output swts_pkg::cfg_t                 cfg_o
);
  import swts_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegSessionId:  cfg_d.sess_key    = cfg_wdata_i;
        RegProtocolId: ;
        RegTotalLen:   cfg_d.total_len   = cfg_wdata_i[31:0];
        RegServerIp:   cfg_d.server_ip   = cfg_wdata_i[31:0];
        RegServerPort: cfg_d.server_port = cfg_wdata_i[15:0];
        RegMaxRetx:    cfg_d.max_retx    = cfg_wdata_i[7:0];
        RegMaxChunk:   cfg_d.max_chunk   = cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sess_key    <= '0;
      cfg_q.total_len   <= '0;
      cfg_q.server_ip   <= '0;
      cfg_q.server_port <= '0;
      cfg_q.max_retx    <= 8'd3;
      cfg_q.max_chunk   <= 16'd64000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- sv/swts_front.sv -----
// Front end: classifies an incoming event word against the configuration.
// Depends on swts_pkg for the packet codes and the evt_t bundle.
module swts_front (
  input  swts_pkg::cfg_t  cfg_i,
  input  logic [1:0]      cmd_i,
  input  logic [31:0]     from_ip_i,
  input  logic [15:0]     from_port_i,
  input  logic [15:0]     rx_len_i,
  input  logic [7:0]      rx_type_i,
  input  logic [63:0]     rx_session_i,
  input  logic [63:0]     rx_number_i,
  output swts_pkg::evt_t  evt_o
);
  import swts_pkg::*;

  always_comb begin
    evt_o.cmd         = cmd_e'(cmd_i);
    evt_o.src_ok      = (from_ip_i == cfg_i.server_ip) && (from_port_i == cfg_i.server_port);
    evt_o.len_short   = (rx_len_i == ShortPktLen);
    evt_o.len_ack     = (rx_len_i == AckPktLen);
    evt_o.is_accept   = (rx_type_i == TypeAccept);
    evt_o.is_reject   = (rx_type_i == TypeReject);
    evt_o.is_ack      = (rx_type_i == TypeAck);
    evt_o.is_received = (rx_type_i == TypeReceived);
    evt_o.sess_ok     = (rx_session_i == cfg_i.sess_key);
    evt_o.number      = rx_number_i;
  end

endmodule

// ----- sv/swts_queue.sv -----
// Short queue of classified event words between the front and back ends.
// Depends on swts_pkg for the queue depth and the evt_t bundle.
module swts_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  swts_pkg::evt_t  push_data_i,
  output logic            ready_o,
  input  logic            pop_i,
  output logic            valid_o,
  output swts_pkg::evt_t  pop_data_o
);
  import swts_pkg::*;

  evt_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign ready_o    = (cnt_q != CntW'(QueueDepth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ----- sv/swts_back.sv -----
// Back end: transfer state machine and the output register of the sender.
// Depends on swts_pkg for codes, cfg_t, evt_t and res_t.
module swts_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  swts_pkg::cfg_t  cfg_i,
  input  logic            evt_valid_i,
  input  swts_pkg::evt_t  evt_i,
  output logic            evt_pop_o,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output swts_pkg::res_t  res_o
);
  import swts_pkg::*;

  localparam logic [2:0] PhIdle = 3'd0;
  localparam logic [2:0] PhConn = 3'd1;
  localparam logic [2:0] PhData = 3'd2;
  localparam logic [2:0] PhRcvd = 3'd3;
  localparam logic [2:0] PhDone = 3'd4;

  logic [2:0]  phase_q, phase_d;
  logic [8:0]  attempt_q, attempt_d;
  logic [63:0] num_q, num_d;
  logic [31:0] off_q, off_d;
  logic [15:0] chunk_q, chunk_d;
  logic        out_valid_q, out_valid_d;
  res_t        out_q, out_d;

  logic        fire, waiting, emit, do_fail, do_next;
  logic [2:0]  fail_st;
  logic [31:0] total, nc_base, rest;
  logic [15:0] lim, nc_chunk;
  logic [63:0] nc_num;
  logic        nc_empty;
  logic [8:0]  attempt_inc;
  res_t        res;

  always_comb begin
    fire        = evt_valid_i && (!out_valid_q || res_ready_i);
    waiting     = (phase_q == PhConn) || (phase_q == PhData) || (phase_q == PhRcvd);
    total       = cfg_i.total_len & LenMask;
    lim         = (cfg_i.max_chunk == '0) ? 16'd1 : cfg_i.max_chunk;
    nc_base     = (phase_q == PhData) ? off_q + 32'(chunk_q) : '0;
    nc_num      = (phase_q == PhData) ? num_q + 64'd1 : '0;
    nc_empty    = (nc_base >= total);
    rest        = total - nc_base;
    nc_chunk    = (rest > 32'(lim)) ? lim : rest[15:0];
    attempt_inc = attempt_q + 9'd1;

    phase_d   = phase_q;
    attempt_d = attempt_q;
    num_d     = num_q;
    off_d     = off_q;
    chunk_d   = chunk_q;
    emit      = 1'b0;
    do_fail   = 1'b0;
    do_next   = 1'b0;
    fail_st   = StOk;
    res       = '0;

    if (evt_i.cmd == CmdStart) begin
      phase_d    = PhConn;
      attempt_d  = '0;
      num_d      = '0;
      off_d      = '0;
      chunk_d    = '0;
      emit       = 1'b1;
      res.action = ActConn;
    end else if (waiting) begin
      unique case (evt_i.cmd)
        CmdPacket: begin
          if (evt_i.src_ok) begin
            unique case (phase_q)
              PhConn: begin
                if (!evt_i.len_short) begin
                  do_fail = 1'b1;
                  fail_st = StSize;
                end else if (evt_i.is_reject) begin
                  do_fail = 1'b1;
                  fail_st = StReject;
                end else if (!evt_i.is_accept) begin
                  do_fail = 1'b1;
                  fail_st = StType;
                end else if (!evt_i.sess_ok) begin
                  do_fail = 1'b1;
                  fail_st = StSession;
                end else begin
                  do_next = 1'b1;
                end
              end
              PhData: begin
                if ((num_q == '0) && evt_i.len_short && evt_i.is_accept) begin
                  do_next = 1'b0;
                end else if (!evt_i.len_ack) begin
                  do_fail = 1'b1;
                  fail_st = StSize;
                end else if (!evt_i.is_ack) begin
                  do_fail = 1'b1;
                  fail_st = StType;
                end else if (!evt_i.sess_ok) begin
                  do_fail = 1'b1;
                  fail_st = StSession;
                end else if (evt_i.number < num_q) begin
                  do_next = 1'b0;
                end else if (evt_i.number != num_q) begin
                  do_fail = 1'b1;
                  fail_st = StNumber;
                end else begin
                  do_next = 1'b1;
                end
              end
              default: begin
                if (evt_i.len_ack && evt_i.is_ack) begin
                  do_next = 1'b0;
                end else if (!evt_i.len_short) begin
                  do_fail = 1'b1;
                  fail_st = StSize;
                end else if (!evt_i.is_received) begin
                  do_fail = 1'b1;
                  fail_st = StType;
                end else if (!evt_i.sess_ok) begin
                  do_fail = 1'b1;
                  fail_st = StSession;
                end else begin
                  phase_d    = PhDone;
                  emit       = 1'b1;
                  res.action = ActOk;
                end
              end
            endcase
          end
        end
        CmdTimeout: begin
          if (phase_q == PhRcvd) begin
            do_fail = 1'b1;
            fail_st = StRetry;
          end else begin
            attempt_d = attempt_inc;
            if (attempt_inc > 9'(cfg_i.max_retx)) begin
              do_fail = 1'b1;
              fail_st = StRetry;
            end else if (phase_q == PhConn) begin
              emit       = 1'b1;
              res.action = ActConn;
            end else begin
              emit            = 1'b1;
              res.action      = ActData;
              res.seq_number  = num_q;
              res.data_offset = off_q;
              res.chunk_len   = chunk_q;
            end
          end
        end
        CmdSockErr: begin
          do_fail = 1'b1;
          fail_st = StSocket;
        end
        default: ;
      endcase
    end

    if (do_fail) begin
      phase_d    = PhDone;
      emit       = 1'b1;
      res        = '0;
      res.action = ActFail;
      res.status = fail_st;
    end

    if (do_next) begin
      attempt_d = '0;
      off_d     = nc_base;
      num_d     = nc_num;
      if (nc_empty) begin
        phase_d = PhRcvd;
        chunk_d = '0;
      end else begin
        phase_d         = PhData;
        chunk_d         = nc_chunk;
        emit            = 1'b1;
        res.action      = ActData;
        res.seq_number  = nc_num;
        res.data_offset = nc_base;
        res.chunk_len   = nc_chunk;
      end
    end

    out_valid_d = out_valid_q && !res_ready_i;
    out_d       = out_q;
    if (fire && emit) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      attempt_q   <= '0;
      num_q       <= '0;
      off_q       <= '0;
      chunk_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        phase_q   <= phase_d;
        attempt_q <= attempt_d;
        num_q     <= num_d;
        off_q     <= off_d;
        chunk_q   <= chunk_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  assign evt_pop_o   = fire;
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

// ----- sv/stop_and_wait_transfer_sender.sv -----
// Top level of the stop-and-wait transfer sender.
// Depends on swts_pkg, swts_cfg, swts_front, swts_queue and swts_back.
//
// The input channel carries one event word per handshake: start, packet
// arrived (with its source, length, type, session and number), timeout or
// socket error. The output channel carries at most one word per event that
// tells the host to send a connect request or a data chunk, or reports the
// final status. Events that cause no result produce no output word.
// The user must write the configuration port only while no event or result
// is in flight; the block does not enforce this. A written value takes effect
// at once, also during a transfer. An accepted event is classified at once and
// queued in a two-entry queue; the state machine takes one word per cycle from
// it unless a stalled result holds the output register, which registers each
// result. The block sustains one event per cycle while the receiver does
// not stall, limited by the single state update. When the receiver stalls, the
// result waits in the output register and the queue absorbs up to two more
// events before in_ready_o drops. Reset empties the queue and the output
// register, returns the state machine to idle and loads the register defaults.
module stop_and_wait_transfer_sender (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [swts_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [swts_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     cmd_i,
  input  logic [31:0]                    from_ip_i,
  input  logic [15:0]                    from_port_i,
  input  logic [15:0]                    rx_len_i,
  input  logic [7:0]                     rx_type_i,
  input  logic [63:0]                    rx_session_i,
  input  logic [63:0]                    rx_number_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     action_o,
  output logic [63:0]                    seq_number_o,
  output logic [31:0]                    data_offset_o,
  output logic [15:0]                    chunk_len_o,
  output logic [2:0]                     status_o
);
  import swts_pkg::*;

  cfg_t cfg;
  evt_t evt_in, evt_head;
  res_t res;
  logic q_ready, q_valid, q_pop;

  swts_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  swts_front u_front (
    .cfg_i        (cfg),
    .cmd_i        (cmd_i),
    .from_ip_i    (from_ip_i),
    .from_port_i  (from_port_i),
    .rx_len_i     (rx_len_i),
    .rx_type_i    (rx_type_i),
    .rx_session_i (rx_session_i),
    .rx_number_i  (rx_number_i),
    .evt_o        (evt_in)
  );

  swts_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i && q_ready),
    .push_data_i (evt_in),
    .ready_o     (q_ready),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (evt_head)
  );

  swts_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .evt_valid_i (q_valid),
    .evt_i       (evt_head),
    .evt_pop_o   (q_pop),
    .res_valid_o (out_valid_o),
    .res_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign in_ready_o    = q_ready;
  assign action_o      = res.action;
  assign seq_number_o  = res.seq_number;
  assign data_offset_o = res.data_offset;
  assign chunk_len_o   = res.chunk_len;
  assign status_o      = res.status;

endmodule

// ----- sv/swts_checker.sv -----
// Port-level checker of the transfer sender, bound to the top level.
// Depends on swts_pkg and stop_and_wait_transfer_sender_defines.svh.
`include "stop_and_wait_transfer_sender_defines.svh"

module swts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  action_o,
  input logic [63:0] seq_number_o,
  input logic [31:0] data_offset_o,
  input logic [15:0] chunk_len_o,
  input logic [2:0]  status_o
);
  import swts_pkg::*;

  `SWTS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(action_o) && $stable(status_o) && $stable(chunk_len_o),
    "Stalled output word changed.")

  `SWTS_ASSERT_NOW(a_nodata_zero, out_valid_o && (action_o != ActData),
    (seq_number_o == '0) && (data_offset_o == '0) && (chunk_len_o == '0),
    "Chunk fields set on a word that is not a data send.")

  `SWTS_ASSERT_NOW(a_status_fail, out_valid_o && (action_o != ActFail),
    status_o == StOk, "Status set on a word that is not a failure.")

  `SWTS_ASSERT_NOW(a_chunk_nonzero, out_valid_o && (action_o == ActData),
    chunk_len_o != '0, "Data send with an empty chunk.")

endmodule

bind stop_and_wait_transfer_sender swts_checker u_swts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .action_o      (action_o),
  .seq_number_o  (seq_number_o),
  .data_offset_o (data_offset_o),
  .chunk_len_o   (chunk_len_o),
  .status_o      (status_o)
);

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the stop-and-wait transfer sender: directed event
// sequences, then random transfers, checked word by word against a predictor.
// Depends on swts_pkg and stop_and_wait_transfer_sender; reads no files.
module tb_top;
  import swts_pkg::*;

  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned RandomWords = 1700;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned DrainLimit  = 4000;

  typedef enum logic [2:0] {
    PhIdle, PhConnect, PhData, PhConfirm, PhDone
  } sender_phase_e;

  typedef struct {
    cmd_e        cmd;
    logic [31:0] from_ip;
    logic [15:0] from_port;
    logic [15:0] rx_len;
    logic [7:0]  rx_type;
    logic [63:0] rx_session;
    logic [63:0] rx_number;
  } link_evt_t;

  typedef struct {
    logic [63:0] sess_key;
    logic [7:0]  proto_code;
    logic [31:0] total_len;
    logic [31:0] server_ip;
    logic [15:0] server_port;
    logic [7:0]  max_retx;
    logic [15:0] max_chunk;
  } link_cfg_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          cmd = '0;
  logic [31:0]         from_ip = '0;
  logic [15:0]         from_port = '0;
  logic [15:0]         rx_len = '0;
  logic [7:0]          rx_type = '0;
  logic [63:0]         rx_session = '0;
  logic [63:0]         rx_number = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [1:0]          action;
  logic [63:0]         seq_number;
  logic [31:0]         data_offset;
  logic [15:0]         chunk_len;
  logic [2:0]          status;

  link_cfg_t     live_cfg;
  sender_phase_e sender_phase;
  logic [8:0]    retries;
  logic [63:0]   pending_number;
  logic [31:0]   acked_offset;
  logic [15:0]   pending_chunk;

  res_t        expected_words[$];
  res_t        due_word;
  int unsigned words_sent = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  int unsigned stall_roll;
  bit          tx_gaps_on = 1'b1;
  bit          rx_stalls_on = 1'b1;

  stop_and_wait_transfer_sender DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .cmd_i         (cmd),
    .from_ip_i     (from_ip),
    .from_port_i   (from_port),
    .rx_len_i      (rx_len),
    .rx_type_i     (rx_type),
    .rx_session_i  (rx_session),
    .rx_number_i   (rx_number),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .action_o      (action),
    .seq_number_o  (seq_number),
    .data_offset_o (data_offset),
    .chunk_len_o   (chunk_len),
    .status_o      (status)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if (!rx_stalls_on) begin
      out_ready <= 1'b1;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 75) begin
        out_ready <= 1'b1;
      end else if (stall_roll < 96) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(10, 40);
      end
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    if (error_count <= 40) begin
      $display("mismatch: %s got 0x%0h expected 0x%0h", what, got, want);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("word with nothing expected, action", 64'(action), 64'd0);
      end else begin
        due_word = expected_words.pop_front();
        if (action !== due_word.action)
          report_mismatch("action", 64'(action), 64'(due_word.action));
        if (seq_number !== due_word.seq_number)
          report_mismatch("seq_number", seq_number, due_word.seq_number);
        if (data_offset !== due_word.data_offset)
          report_mismatch("data_offset", 64'(data_offset), 64'(due_word.data_offset));
        if (chunk_len !== due_word.chunk_len)
          report_mismatch("chunk_len", 64'(chunk_len), 64'(due_word.chunk_len));
        if (status !== due_word.status)
          report_mismatch("status", 64'(status), 64'(due_word.status));
      end
    end
  end

  function automatic bit transfer_open();
    return sender_phase == PhConnect || sender_phase == PhData ||
           sender_phase == PhConfirm;
  endfunction

  function automatic bit chunk_word(output res_t r);
    r = '0;
    r.action = ActData;
    r.seq_number = pending_number;
    r.data_offset = acked_offset;
    r.chunk_len = pending_chunk;
    return 1'b1;
  endfunction

  function automatic bit fail_word(input logic [2:0] st, output res_t r);
    sender_phase = PhDone;
    r = '0;
    r.action = ActFail;
    r.status = st;
    return 1'b1;
  endfunction

  // Picks the chunk at the acknowledged offset, or moves on to the final
  // confirmation once the whole payload has been acknowledged.
  function automatic bit advance_chunk(output res_t r);
    logic [31:0] total;
    logic [31:0] rest;
    logic [15:0] lim;
    total = live_cfg.total_len & LenMask;
    lim = (live_cfg.max_chunk == 16'd0) ? 16'd1 : live_cfg.max_chunk;
    retries = '0;
    r = '0;
    if (acked_offset >= total) begin
      sender_phase = PhConfirm;
      pending_chunk = '0;
      return 1'b0;
    end
    rest = total - acked_offset;
    pending_chunk = (rest > {16'd0, lim}) ? lim : rest[15:0];
    sender_phase = PhData;
    return chunk_word(r);
  endfunction

  function automatic bit next_sender_word(input link_evt_t ev, output res_t r);
    r = '0;
    if (ev.cmd == CmdStart) begin
      sender_phase = PhConnect;
      retries = '0;
      pending_number = '0;
      acked_offset = '0;
      pending_chunk = '0;
      r.action = ActConn;
      return 1'b1;
    end
    if (!transfer_open()) return 1'b0;
    case (ev.cmd)
      CmdTimeout: begin
        if (sender_phase == PhConfirm) return fail_word(StRetry, r);
        retries = retries + 9'd1;
        if (retries > {1'b0, live_cfg.max_retx}) return fail_word(StRetry, r);
        if (sender_phase == PhConnect) begin
          r.action = ActConn;
          return 1'b1;
        end
        return chunk_word(r);
      end
      CmdSockErr: return fail_word(StSocket, r);
      default: ;
    endcase
    if (ev.from_ip != live_cfg.server_ip || ev.from_port != live_cfg.server_port)
      return 1'b0;
    case (sender_phase)
      PhConnect: begin
        if (ev.rx_len != ShortPktLen) return fail_word(StSize, r);
        if (ev.rx_type == TypeReject) return fail_word(StReject, r);
        if (ev.rx_type != TypeAccept) return fail_word(StType, r);
        if (ev.rx_session != live_cfg.sess_key) return fail_word(StSession, r);
        acked_offset = '0;
        pending_number = '0;
        return advance_chunk(r);
      end
      PhData: begin
        if (pending_number == 64'd0 && ev.rx_len == ShortPktLen &&
            ev.rx_type == TypeAccept) return 1'b0;
        if (ev.rx_len != AckPktLen) return fail_word(StSize, r);
        if (ev.rx_type != TypeAck) return fail_word(StType, r);
        if (ev.rx_session != live_cfg.sess_key) return fail_word(StSession, r);
        if (ev.rx_number < pending_number) return 1'b0;
        if (ev.rx_number != pending_number) return fail_word(StNumber, r);
        acked_offset = acked_offset + {16'd0, pending_chunk};
        pending_number = pending_number + 64'd1;
        return advance_chunk(r);
      end
      default: begin
        if (ev.rx_len == AckPktLen && ev.rx_type == TypeAck) return 1'b0;
        if (ev.rx_len != ShortPktLen) return fail_word(StSize, r);
        if (ev.rx_type != TypeReceived) return fail_word(StType, r);
        if (ev.rx_session != live_cfg.sess_key) return fail_word(StSession, r);
        sender_phase = PhDone;
        r.action = ActOk;
        return 1'b1;
      end
    endcase
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_edge64();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return rand64();
  endfunction

  function automatic link_evt_t any_event(input cmd_e c);
    link_evt_t e;
    e.cmd = c;
    e.from_ip = $urandom;
    e.from_port = 16'($urandom);
    e.rx_len = 16'($urandom);
    e.rx_type = 8'($urandom);
    e.rx_session = rand64();
    e.rx_number = rand64();
    return e;
  endfunction

  function automatic link_evt_t server_reply(input logic [15:0] len,
                                             input logic [7:0] typ,
                                             input logic [63:0] num);
    link_evt_t e;
    e = any_event(CmdPacket);
    e.from_ip = live_cfg.server_ip;
    e.from_port = live_cfg.server_port;
    e.rx_len = len;
    e.rx_type = typ;
    e.rx_session = live_cfg.sess_key;
    e.rx_number = num;
    return e;
  endfunction

  function automatic link_evt_t from_elsewhere(input link_evt_t e);
    if ($urandom_range(0, 1) != 0) e.from_ip ^= 32'd1 << $urandom_range(0, 31);
    else e.from_port ^= 16'd1 << $urandom_range(0, 15);
    return e;
  endfunction

  function automatic link_evt_t fitting_reply();
    case (sender_phase)
      PhConnect: return server_reply(ShortPktLen, TypeAccept, rand64());
      PhData:    return server_reply(AckPktLen, TypeAck, pending_number);
      PhConfirm: return server_reply(ShortPktLen, TypeReceived, rand64());
      default:   return any_event(CmdStart);
    endcase
  endfunction

  function automatic link_evt_t harmless_reply();
    case (sender_phase)
      PhData: begin
        if (pending_number != 64'd0)
          return server_reply(AckPktLen, TypeAck, pending_number - 64'd1);
        return server_reply(ShortPktLen, TypeAccept, rand64());
      end
      PhConfirm: return server_reply(AckPktLen, TypeAck, rand64());
      default:   return from_elsewhere(fitting_reply());
    endcase
  endfunction

  function automatic link_evt_t broken_reply();
    link_evt_t e;
    e = fitting_reply();
    case ($urandom_range(0, 4))
      0: e.rx_len = 16'($urandom);
      1: e.rx_type = 8'($urandom);
      2: e.rx_session ^= 64'd1 << $urandom_range(0, 63);
      3: e.rx_number = pending_number + 64'($urandom_range(1, 3));
      default: e.rx_type = TypeReject;
    endcase
    return e;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (!tx_gaps_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_event(input link_evt_t ev);
    res_t        word;
    bit          produced;
    int unsigned gap;
    in_valid <= 1'b1;
    cmd <= ev.cmd;
    from_ip <= ev.from_ip;
    from_port <= ev.from_port;
    rx_len <= ev.rx_len;
    rx_type <= ev.rx_type;
    rx_session <= ev.rx_session;
    rx_number <= ev.rx_number;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    produced = next_sender_word(ev, word);
    if (produced) begin
      expected_words.push_back(word);
    end
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    int unsigned waited;
    waited = 0;
    in_valid <= 1'b0;
    while (expected_words.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    if (expected_words.size() != 0) begin
      report_mismatch("words never delivered, count", 64'(expected_words.size()), 64'd0);
      expected_words.delete();
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic write_regs(input link_cfg_t c);
    put_reg(RegSessionId, c.sess_key);
    put_reg(RegProtocolId, 64'(c.proto_code));
    put_reg(RegTotalLen, 64'(c.total_len));
    put_reg(RegServerIp, 64'(c.server_ip));
    put_reg(RegServerPort, 64'(c.server_port));
    put_reg(RegMaxRetx, 64'(c.max_retx));
    put_reg(RegMaxChunk, 64'(c.max_chunk));
    cfg_we <= 1'b0;
    live_cfg = c;
  endtask

  function automatic link_cfg_t random_settings();
    link_cfg_t   c;
    int unsigned roll;
    c.sess_key = rand_edge64();
    c.proto_code = 8'($urandom);
    c.server_ip = 32'(rand_edge64());
    c.server_port = 16'(rand_edge64());
    roll = $urandom_range(0, 9);
    c.max_retx = (roll < 4) ? 8'($urandom_range(0, 3)) :
                 (roll < 8) ? 8'($urandom_range(4, 10)) :
                 (roll == 8) ? 8'hFF : 8'($urandom);
    roll = $urandom_range(0, 9);
    c.max_chunk = (roll < 3) ? 16'($urandom_range(1, 8)) :
                  (roll < 7) ? 16'($urandom_range(9, 64)) :
                  (roll == 7) ? 16'd0 :
                  (roll == 8) ? 16'hFFFF : 16'($urandom);
    roll = $urandom_range(0, 19);
    c.total_len = (roll < 13) ? 32'($urandom_range(1, 64)) :
                  (roll < 16) ? 32'd0 :
                  (roll < 19) ? 32'($urandom_range(65, 300)) : 32'($urandom);
    return c;
  endfunction

  task automatic test_defaults_and_idle();
    send_event(any_event(CmdTimeout));
    send_event(any_event(CmdStart));
    send_event(server_reply(ShortPktLen, TypeAccept, '0));
    send_event(server_reply(AckPktLen, TypeAck, '0));
    send_event(server_reply(ShortPktLen, TypeReceived, '0));
  endtask

  task automatic test_extreme_settings();
    link_cfg_t c;
    c.sess_key = '1;
    c.proto_code = '1;
    c.total_len = '1;
    c.server_ip = '1;
    c.server_port = '1;
    c.max_retx = '0;
    c.max_chunk = '0;
    wait_drained();
    write_regs(c);
    send_event(any_event(CmdStart));
    send_event(from_elsewhere(server_reply(ShortPktLen, TypeAccept, '0)));
    send_event(server_reply(ShortPktLen, TypeAccept, '0));
    send_event(server_reply(ShortPktLen, TypeAccept, '1));
    send_event(server_reply(AckPktLen, TypeAck, 64'd0));
    send_event(server_reply(AckPktLen, TypeAck, 64'd0));
    send_event(server_reply(AckPktLen, TypeAck, '1));
    send_event(any_event(CmdStart));
    send_event(any_event(CmdTimeout));
  endtask

  task automatic test_failure_codes();
    link_cfg_t c;
    link_evt_t ev;
    c.sess_key = rand64();
    c.proto_code = '0;
    c.total_len = 32'd70000;
    c.server_ip = $urandom;
    c.server_port = 16'($urandom);
    c.max_retx = 8'hFF;
    c.max_chunk = 16'hFFFF;
    wait_drained();
    write_regs(c);
    send_event(any_event(CmdStart));
    send_event(server_reply(ShortPktLen, TypeReject, '0));
    send_event(any_event(CmdStart));
    send_event(server_reply(AckPktLen, TypeAccept, '0));
    send_event(any_event(CmdStart));
    send_event(server_reply(ShortPktLen, 8'hFF, '0));
    send_event(any_event(CmdStart));
    ev = server_reply(ShortPktLen, TypeAccept, '0);
    ev.rx_session ^= 64'd1;
    send_event(ev);
    send_event(any_event(CmdStart));
    send_event(any_event(CmdSockErr));
    send_event(any_event(CmdStart));
    send_event(server_reply(ShortPktLen, TypeAccept, '0));
    send_event(any_event(CmdTimeout));
    send_event(server_reply(AckPktLen, TypeAck, 64'd0));
    send_event(server_reply(AckPktLen, TypeAck, 64'd1));
    send_event(any_event(CmdTimeout));
  endtask

  task automatic test_random_transfers();
    int unsigned first_word;
    int unsigned transfers;
    int unsigned steps;
    int unsigned roll;
    link_evt_t   ev;
    first_word = words_sent;
    transfers = 0;
    while (words_sent - first_word < RandomWords) begin
      if (transfers % 4 == 0) begin
        wait_drained();
        write_regs(random_settings());
        tx_gaps_on = ($urandom_range(0, 3) != 0);
        rx_stalls_on = ($urandom_range(0, 3) != 0);
      end
      transfers++;
      send_event(any_event(CmdStart));
      steps = 0;
      while (transfer_open() && steps < 60) begin
        steps++;
        roll = $urandom_range(0, 99);
        if (roll < 62) ev = fitting_reply();
        else if (roll < 72) ev = any_event(CmdTimeout);
        else if (roll < 78) ev = from_elsewhere(fitting_reply());
        else if (roll < 84) ev = harmless_reply();
        else if (roll < 93) ev = broken_reply();
        else if (roll < 95) ev = any_event(CmdSockErr);
        else if (roll < 97) ev = any_event(CmdStart);
        else ev = any_event(cmd_e'($urandom_range(0, 3)));
        send_event(ev);
      end
      if ($urandom_range(0, 19) == 0) begin
        while (transfer_open()) send_event(any_event(CmdTimeout));
      end
      if ($urandom_range(0, 9) == 0)
        send_event(any_event(cmd_e'($urandom_range(1, 3))));
    end
  endtask

  initial begin
    live_cfg.sess_key = '0;
    live_cfg.proto_code = '0;
    live_cfg.total_len = '0;
    live_cfg.server_ip = '0;
    live_cfg.server_port = '0;
    live_cfg.max_retx = 8'd3;
    live_cfg.max_chunk = 16'd64000;
    sender_phase = PhIdle;
    retries = '0;
    pending_number = '0;
    acked_offset = '0;
    pending_chunk = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults_and_idle();
    test_extreme_settings();
    test_failure_codes();
    test_random_transfers();
    wait_drained();
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
